[sv/terminal_input_line_queue_macros.svh]
// Assertion macros shared by the checker of the terminal input line queue.
`ifndef TERMINAL_INPUT_LINE_QUEUE_MACROS_SVH
`define TERMINAL_INPUT_LINE_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TILQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TILQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[sv/tilq_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilq_pkg
// Operation codes, status codes, register indexes and the word type that
// moves along the delimiter compare chain.
// ----------------------------------------------------------------------------
package tilq_pkg;

	typedef enum logic [2:0] {
		OP_WRITE = 3'd0,
		OP_READ  = 3'd1,
		OP_DROP  = 3'd2,
		OP_ERASE = 3'd3,
		OP_FIND  = 3'd4,
		OP_FLUSH = 3'd5
	} op_t;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_FULL     = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;
	localparam logic [1:0] ST_NOTFOUND = 2'd3;

	localparam logic [2:0] CFG_DELIM_A = 3'd0;
	localparam logic [2:0] CFG_DELIM_B = 3'd1;
	localparam logic [2:0] CFG_DELIM_C = 3'd2;
	localparam logic [2:0] CFG_DELIM_D = 3'd3;
	localparam logic [2:0] CFG_ENABLE  = 3'd4;

	localparam int unsigned NUM_DELIM = 4;

	localparam logic [7:0] BYTE_FF = 8'hff;
	localparam logic [7:0] BYTE_00 = 8'h00;

	typedef struct packed {
		logic       v;
		logic       hit;
		logic [7:0] data;
	} tilq_tok_t;

endpackage

[sv/terminal_input_line_queue.sv]
`timescale 1ns / 1ps
// Write, drop, flush and empty or full answers: S_EMIT loads the result word once the
// output is free, then back to S_IDLE for the next word. Read: S_RD_W, then S_RD per byte
// delivered; erase: three serial RAM reads. Find: one byte a cycle through the RAM read
// port and a four-cell compare chain. One item is worked at a time.
// Reset clears head, tail, the state machine and the output; delimiters
// return to 10, 0, 0, 0 with only the first enabled. RAM contents are not reset.
// ----------------------------------------------------------------------------
// terminal_input_line_queue
// Byte ring queue with quote bits, erase of escape sequences and a
// delimiter search over the held bytes.
// ----------------------------------------------------------------------------
module terminal_input_line_queue #(
	parameter int DEPTH     = 4096,
	parameter int MAX_BURST = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  op,
	input  logic [7:0]  char_in,
	input  logic        quote_in,
	input  logic [6:0]  count_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [7:0]  char_out,
	output logic [11:0] count_out,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import tilq_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int HW = (AW > 7) ? AW : 7;

	typedef enum logic [7:0] {
		S_IDLE   = 8'b0000_0001,
		S_EMIT   = 8'b0000_0010,
		S_RD_W   = 8'b0000_0100,
		S_RD     = 8'b0000_1000,
		S_ER_W   = 8'b0001_0000,
		S_ER_C   = 8'b0010_0000,
		S_ER_OUT = 8'b0100_0000,
		S_FIND   = 8'b1000_0000
	} state_t;

	function automatic logic [AW-1:0] ring_inc(input logic [AW-1:0] p);
		return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] p);
		return (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
	endfunction

	state_t        state_q;
	logic [AW-1:0] head_q, tail_q;
	logic [7:0]    delim_q [NUM_DELIM];
	logic [3:0]    den_q;

	logic [AW-1:0] addr_q, idx_q;
	logic [6:0]    n_q, rd_cnt_q;
	logic [1:0]    ek_q;
	logic [7:0]    b1_q, b2_q, b3_q;
	logic          q1_q;
	logic [1:0]    res_st_q;
	logic [7:0]    res_ch_q;
	logic [11:0]   res_cnt_q;
	logic          v_s1;
	logic [AW-1:0] idx_s1;

	logic          out_valid_q, out_last_q;
	logic [1:0]    out_st_q;
	logic [7:0]    out_ch_q;
	logic [11:0]   out_cnt_q;

	logic          accept, out_free, out_load;
	logic [AW-1:0] held, tail_inc, tail_dec;
	logic [AW:0]   wrap_sum, drop_sum;
	logic          full;
	logic [6:0]    n_sat, n_eff;
	logic [8:0]    rdata;
	logic          mem_we;
	logic          rd_last;
	logic [6:0]    rd_next;
	logic          issue;
	logic          er_pair, er_triple;

	tilq_tok_t     tok [NUM_DELIM+1];
	logic [AW-1:0] tidx [NUM_DELIM+1];
	logic          chain_clr;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	assign wrap_sum = {1'b0, tail_q} + (AW+1)'(DEPTH) - {1'b0, head_q};
	assign held     = (tail_q >= head_q) ? (tail_q - head_q) : wrap_sum[AW-1:0];
	assign tail_inc = ring_inc(tail_q);
	assign tail_dec = ring_dec(tail_q);
	assign full     = (tail_inc == head_q);

	assign n_sat = (count_in > 7'(MAX_BURST)) ? 7'(MAX_BURST) : count_in;
	assign n_eff = (HW'(held) < HW'(n_sat)) ? 7'(held) : n_sat;
	assign drop_sum = {1'b0, head_q} + (AW+1)'(n_eff);

	assign mem_we = accept && (op == OP_WRITE) && !full;

	tilq_ram #(.DEPTH(DEPTH), .AW(AW)) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (tail_q),
		.wdata ({quote_in, char_in}),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// Delimiter compare chain, fed one stored byte a cycle during a search.
	assign chain_clr = (state_q != S_FIND);
	assign tok[0]    = '{v: v_s1, hit: 1'b0, data: rdata[7:0]};
	assign tidx[0]   = idx_s1;

	for (genvar g = 0; g < NUM_DELIM; g++) begin : g_cell
		tilq_cell #(.AW(AW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.clr     (chain_clr),
			.delim   (delim_q[g]),
			.en      (den_q[g]),
			.tok_in  (tok[g]),
			.idx_in  (tidx[g]),
			.tok_out (tok[g+1]),
			.idx_out (tidx[g+1])
		);
	end

	assign issue     = (state_q == S_FIND) && (idx_q != held);
	assign rd_next   = rd_cnt_q + 1'b1;
	assign rd_last   = (rd_next == n_q);
	assign er_pair   = q1_q && (b1_q == BYTE_FF) && (held >= AW'(2)) && (b2_q == BYTE_FF);
	assign er_triple = q1_q && (b1_q != BYTE_FF) && (held >= AW'(3)) &&
		(b3_q == BYTE_FF) && (b2_q == BYTE_00);
	assign out_load  = ((state_q == S_EMIT) || (state_q == S_RD)) && out_free;

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
			delim_q[0]  <= 8'd10;
			delim_q[1]  <= 8'd0;
			delim_q[2]  <= 8'd0;
			delim_q[3]  <= 8'd0;
			den_q       <= 4'd1;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_DELIM_A: delim_q[0] <= cfg_data;
					CFG_DELIM_B: delim_q[1] <= cfg_data;
					CFG_DELIM_C: delim_q[2] <= cfg_data;
					CFG_DELIM_D: delim_q[3] <= cfg_data;
					CFG_ENABLE:  den_q      <= cfg_data[3:0];
					default: ;
				endcase
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			v_s1 <= issue;

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						priority if (op == OP_WRITE) begin
							if (!full) tail_q <= tail_inc;
							state_q <= S_EMIT;
						end else if (op == OP_READ) begin
							state_q <= (held != '0 && n_eff != '0) ? S_RD_W : S_EMIT;
						end else if (op == OP_DROP) begin
							if (held != '0) begin
								head_q <= (drop_sum >= (AW+1)'(DEPTH)) ?
									AW'(drop_sum - (AW+1)'(DEPTH)) : drop_sum[AW-1:0];
							end
							state_q <= S_EMIT;
						end else if (op == OP_ERASE) begin
							state_q <= (held != '0) ? S_ER_W : S_EMIT;
						end else if (op == OP_FIND) begin
							state_q <= (held != '0) ? S_FIND : S_EMIT;
						end else if (op == OP_FLUSH) begin
							head_q  <= '0;
							tail_q  <= '0;
							state_q <= S_EMIT;
						end else begin
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: begin
					if (out_free) state_q <= S_IDLE;
				end
				S_RD_W: state_q <= S_RD;
				S_RD: begin
					if (out_free) begin
						head_q  <= ring_inc(head_q);
						state_q <= rd_last ? S_IDLE : S_RD_W;
					end
				end
				S_ER_W: state_q <= S_ER_C;
				S_ER_C: state_q <= (ek_q == 2'd2) ? S_ER_OUT : S_ER_W;
				S_ER_OUT: begin
					if (er_pair) begin
						tail_q <= ring_dec(ring_dec(tail_q));
					end else if (er_triple) begin
						tail_q <= ring_dec(ring_dec(tail_dec));
					end else begin
						tail_q <= tail_dec;
					end
					state_q <= S_EMIT;
				end
				S_FIND: begin
					if (tok[NUM_DELIM].v &&
						(tok[NUM_DELIM].hit || tidx[NUM_DELIM] == held - 1'b1)) begin
						state_q <= S_EMIT;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Addresses, counters and result words.
	always_ff @(posedge clk) begin
		idx_s1 <= idx_q;
		if (issue) begin
			addr_q <= ring_inc(addr_q);
			idx_q  <= idx_q + 1'b1;
		end

		unique case (state_q)
			S_IDLE: begin
				n_q       <= n_eff;
				rd_cnt_q  <= '0;
				ek_q      <= '0;
				idx_q     <= '0;
				res_ch_q  <= '0;
				res_cnt_q <= '0;
				res_st_q  <= ST_OK;
				if (op == OP_ERASE) begin
					addr_q <= tail_dec;
				end else begin
					addr_q <= head_q;
				end
				if (held == '0 && (op == OP_READ || op == OP_DROP || op == OP_ERASE ||
					op == OP_FIND)) begin
					res_st_q <= ST_EMPTY;
				end else if (op == OP_WRITE && full) begin
					res_st_q <= ST_FULL;
				end else if (op == OP_DROP) begin
					res_cnt_q <= 12'(n_eff);
				end
			end
			S_RD: begin
				if (out_free) begin
					rd_cnt_q <= rd_next;
					addr_q   <= ring_inc(addr_q);
				end
			end
			S_ER_C: begin
				unique case (ek_q)
					2'd0: begin
						b1_q <= rdata[7:0];
						q1_q <= rdata[8];
					end
					2'd1: b2_q <= rdata[7:0];
					default: b3_q <= rdata[7:0];
				endcase
				ek_q   <= ek_q + 1'b1;
				addr_q <= ring_dec(addr_q);
			end
			S_ER_OUT: begin
				res_st_q <= ST_OK;
				if (er_pair) begin
					res_ch_q  <= BYTE_FF;
					res_cnt_q <= 12'd2;
				end else if (er_triple) begin
					res_ch_q  <= b1_q;
					res_cnt_q <= 12'd3;
				end else begin
					res_ch_q  <= b1_q;
					res_cnt_q <= 12'd1;
				end
			end
			S_FIND: begin
				if (tok[NUM_DELIM].v && tok[NUM_DELIM].hit) begin
					res_st_q  <= ST_OK;
					res_ch_q  <= tok[NUM_DELIM].data;
					res_cnt_q <= 12'({1'b0, tidx[NUM_DELIM]} + 1'b1);
				end else begin
					res_st_q  <= ST_NOTFOUND;
					res_ch_q  <= '0;
					res_cnt_q <= '0;
				end
			end
			default: ;
		endcase

		if (out_load) begin
			if (state_q == S_RD) begin
				out_st_q   <= ST_OK;
				out_ch_q   <= rdata[7:0];
				out_cnt_q  <= 12'(rd_next);
				out_last_q <= rd_last;
			end else begin
				out_st_q   <= res_st_q;
				out_ch_q   <= res_ch_q;
				out_cnt_q  <= res_cnt_q;
				out_last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status    = out_st_q;
	assign char_out  = out_ch_q;
	assign count_out = out_cnt_q;
	assign last      = out_last_q;

endmodule

[sv/tilq_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilq_ram
// Ring storage: one write port and one registered read port. Each entry is
// a quote bit above a byte.
// ----------------------------------------------------------------------------
module tilq_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [8:0]    wdata,
	input  logic [AW-1:0] raddr,
	output logic [8:0]    rdata
);

	logic [8:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[sv/tilq_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tilq_cell
// One stage of the delimiter compare chain: checks the passing byte against
// one delimiter and hands the word and its index to the next cell.
// ----------------------------------------------------------------------------
module tilq_cell #(
	parameter int AW = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                clr,
	input  logic [7:0]          delim,
	input  logic                en,
	input  tilq_pkg::tilq_tok_t tok_in,
	input  logic [AW-1:0]       idx_in,
	output tilq_pkg::tilq_tok_t tok_out,
	output logic [AW-1:0]       idx_out
);
	import tilq_pkg::*;

	logic          v_q;
	logic          hit_q;
	logic [7:0]    data_q;
	logic [AW-1:0] idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			v_q <= clr ? 1'b0 : tok_in.v;
		end
	end

	always_ff @(posedge clk) begin
		hit_q  <= tok_in.hit | (en && (tok_in.data == delim));
		data_q <= tok_in.data;
		idx_q  <= idx_in;
	end

	assign tok_out = '{v: v_q, hit: hit_q, data: data_q};
	assign idx_out = idx_q;

endmodule

[sv/tilq_checker.sv]
`timescale 1ns / 1ps
`include "terminal_input_line_queue_macros.svh"
// ----------------------------------------------------------------------------
// tilq_checker
// Port-level checks of the terminal input line queue, bound to the top level.
// ----------------------------------------------------------------------------
module tilq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [7:0]  char_out,
	input logic [11:0] count_out,
	input logic        last
);
	import tilq_pkg::*;

	`TILQ_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall,
		out_valid && $stable(status) && $stable(char_out) && $stable(count_out),
		"stalled output word changed")

	`TILQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && !in_stall, in_stall,
		"new word taken while the previous one is in work")

	`TILQ_ASSERT_NOW(a_partial_is_ok, clk, arst_n, out_valid && !last, status == ST_OK,
		"non-final word carries an error status")

	`TILQ_ASSERT_NOW(a_full_clean, clk, arst_n, out_valid && status == ST_FULL,
		last && char_out == 8'd0 && count_out == 12'd0,
		"full answer carries data")

endmodule

bind terminal_input_line_queue tilq_checker u_tilq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.char_out  (char_out),
	.count_out (count_out),
	.last      (last)
);

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the terminal input line queue. A driver sends
// queued operations in random bursts, a monitor checks every result word
// against a behavioral copy of the queue, and the receiver stalls at random.
// ----------------------------------------------------------------------------
module tb;
	import tilq_pkg::*;

	localparam int DEPTH = 4096;
	localparam int MAX_BURST = 64;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct {
		logic [2:0] op;
		logic [7:0] ch;
		logic       quote;
		logic [6:0] count;
	} cmd_t;

	typedef struct {
		logic [1:0]  status;
		logic [7:0]  ch;
		logic [11:0] count;
		logic        last;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  op;
	logic [7:0]  char_in;
	logic        quote_in;
	logic [6:0]  count_in;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [7:0]  char_out;
	logic [11:0] count_out;
	logic        last;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [7:0]  cfg_data;

	terminal_input_line_queue DUT (.*);

	// Model of the queue.
	logic [7:0]  line_bytes [DEPTH];
	logic        line_quotes [DEPTH];
	logic [11:0] head_ptr;
	logic [11:0] tail_ptr;
	logic [7:0]  delims [NUM_DELIM];
	logic [3:0]  delim_en;

	cmd_t   pending_cmds[$];
	reply_t expected_replies[$];
	int     error_count;
	int     idle_cycles;
	int     burst_left;
	int     gap_left;
	int     hold_off;
	bit     long_hold_done;
	bit     stimulus_done;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic void push_reply(logic [1:0] st, logic [7:0] ch, logic [11:0] n,
			logic lst);
		reply_t r;
		r.status = st;
		r.ch = ch;
		r.count = n;
		r.last = lst;
		expected_replies.push_back(r);
	endfunction

	function automatic bit is_delimiter(logic [7:0] b);
		bit hit;
		hit = 0;
		for (int k = 0; k < NUM_DELIM; k++)
			if (delim_en[k] && b == delims[k])
				hit = 1;
		return hit;
	endfunction

	// Works out the result words of one accepted operation and updates the model.
	function automatic void predict_queue_op(cmd_t c);
		logic [11:0] held;
		logic [11:0] p1;
		logic [11:0] p2;
		logic [11:0] p3;
		logic [11:0] pos;
		int n;
		bit found;
		held = tail_ptr - head_ptr;
		n = (c.count > MAX_BURST) ? MAX_BURST : c.count;
		case (c.op)
			OP_WRITE: begin
				if (tail_ptr + 12'd1 == head_ptr) begin
					push_reply(ST_FULL, 0, 0, 1);
				end else begin
					line_bytes[tail_ptr] = c.ch;
					line_quotes[tail_ptr] = c.quote;
					tail_ptr++;
					push_reply(ST_OK, 0, 0, 1);
				end
			end
			OP_READ: begin
				if (held == 0)
					push_reply(ST_EMPTY, 0, 0, 1);
				else if (n == 0)
					push_reply(ST_OK, 0, 0, 1);
				else begin
					if (n > held)
						n = held;
					for (int i = 0; i < n; i++) begin
						push_reply(ST_OK, line_bytes[head_ptr], 12'(i + 1), i + 1 == n);
						head_ptr++;
					end
				end
			end
			OP_DROP: begin
				if (held == 0)
					push_reply(ST_EMPTY, 0, 0, 1);
				else begin
					if (n > held)
						n = held;
					head_ptr += 12'(n);
					push_reply(ST_OK, 0, 12'(n), 1);
				end
			end
			OP_ERASE: begin
				if (held == 0) begin
					push_reply(ST_EMPTY, 0, 0, 1);
				end else begin
					p1 = tail_ptr - 12'd1;
					p2 = tail_ptr - 12'd2;
					p3 = tail_ptr - 12'd3;
					found = 0;
					if (line_quotes[p1]) begin
						if (line_bytes[p1] == BYTE_FF) begin
							if (held >= 2 && line_bytes[p2] == BYTE_FF) begin
								line_quotes[p1] = 0;
								line_quotes[p2] = 0;
								tail_ptr = p2;
								push_reply(ST_OK, BYTE_FF, 2, 1);
								found = 1;
							end
						end else if (held >= 3 && line_bytes[p3] == BYTE_FF
								&& line_bytes[p2] == BYTE_00) begin
							line_quotes[p1] = 0;
							line_quotes[p2] = 0;
							line_quotes[p3] = 0;
							tail_ptr = p3;
							push_reply(ST_OK, line_bytes[p1], 3, 1);
							found = 1;
						end
					end
					if (!found) begin
						line_quotes[p1] = 0;
						tail_ptr = p1;
						push_reply(ST_OK, line_bytes[p1], 1, 1);
					end
				end
			end
			OP_FIND: begin
				if (held == 0) begin
					push_reply(ST_EMPTY, 0, 0, 1);
				end else begin
					pos = head_ptr;
					found = 0;
					for (int i = 0; i < held && !found; i++) begin
						if (is_delimiter(line_bytes[pos])) begin
							push_reply(ST_OK, line_bytes[pos], 12'(i + 1), 1);
							found = 1;
						end
						pos++;
					end
					if (!found)
						push_reply(ST_NOTFOUND, 0, 0, 1);
				end
			end
			OP_FLUSH: begin
				head_ptr = 0;
				tail_ptr = 0;
				push_reply(ST_OK, 0, 0, 1);
			end
			default: push_reply(ST_OK, 0, 0, 1);
		endcase
	endfunction

	function automatic void add_cmd(logic [2:0] o, logic [7:0] ch, logic q, logic [6:0] n);
		cmd_t c;
		c.op = o;
		c.ch = ch;
		c.quote = q;
		c.count = n;
		pending_cmds.push_back(c);
	endfunction

	function automatic void add_write(logic [7:0] ch, logic q);
		add_cmd(OP_WRITE, ch, q, 7'($urandom));
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() != 0 || expected_replies.size() != 0)
			@(posedge clk);
		// A write leaves nothing behind, but let any search finish anyway.
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [7:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_ENABLE)
			delim_en = val[3:0];
		else
			delims[idx] = val;
	endtask

	// Driver: bursts of offered words separated by random gaps. The word on
	// the port is always the head of the pending queue.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left <= 0;
			gap_left <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_queue_op(pending_cmds.pop_front());
			end
			if (in_valid && in_stall) begin
				// Hold the stalled word.
			end else if (gap_left > 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (pending_cmds.size() > 0) begin
				cmd_t c;
				c = pending_cmds[0];
				in_valid <= 1'b1;
				op <= c.op;
				char_in <= c.ch;
				quote_in <= c.quote;
				count_in <= c.count;
				if (burst_left == 0) begin
					burst_left <= $urandom_range(1, 12);
					gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end else begin
					burst_left <= burst_left - 1;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver stall pattern, with a long hold-off that starts the first
	// time the sender is kept waiting and further long hold-offs at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_off <= 0;
			long_hold_done <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_stall <= hold_off > 1;
		end else if ((!long_hold_done && in_valid && in_stall) ||
				$urandom_range(0, 999) == 0) begin
			hold_off <= 300;
			out_stall <= 1'b1;
			long_hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 15) < 5) && ($urandom_range(0, 7) != 0);
		end
	end

	// Monitor.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_replies.size() == 0) begin
				report("result word with nothing expected");
			end else begin
				reply_t e;
				e = expected_replies.pop_front();
				if (status !== e.status)
					report($sformatf("status %0d, expected %0d", status, e.status));
				if (char_out !== e.ch)
					report($sformatf("char_out %0h, expected %0h", char_out, e.ch));
				if (count_out !== e.count)
					report($sformatf("count_out %0d, expected %0d", count_out, e.count));
				if (last !== e.last)
					report($sformatf("last %0b, expected %0b", last, e.last));
			end
		end
	end

	// Watchdog on cycles without any accepted input or result word, until the stimulus is done.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || stimulus_done)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 5))
			0: return BYTE_FF;
			1: return BYTE_00;
			2: return delims[$urandom_range(0, 3)];
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [6:0] pick_count();
		case ($urandom_range(0, 9))
			0: return 7'd0;
			1: return 7'($urandom_range(65, 127));
			2: return 7'd64;
			default: return 7'($urandom_range(1, 8));
		endcase
	endfunction

	task automatic random_phase(int items);
		for (int i = 0; i < items; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: add_write(pick_byte(), 1'($urandom));
				8: begin
					// Escape pair or triple followed by an erase.
					add_write(BYTE_FF, 1'($urandom));
					if ($urandom_range(0, 1)) begin
						add_write(BYTE_FF, 1'b1);
					end else begin
						add_write(BYTE_00, 1'($urandom));
						add_write(8'($urandom), 1'b1);
					end
					add_cmd(OP_ERASE, 8'($urandom), 1'($urandom), 7'($urandom));
				end
				9, 10: add_cmd(OP_READ, 8'($urandom), 1'($urandom), pick_count());
				11, 12: add_cmd(OP_DROP, 8'($urandom), 1'($urandom), pick_count());
				13, 14: add_cmd(OP_ERASE, 8'($urandom), 1'($urandom), 7'($urandom));
				15, 16, 17: add_cmd(OP_FIND, 8'($urandom), 1'($urandom), 7'($urandom));
				18: add_cmd(($urandom_range(0, 9) == 0) ? OP_FLUSH : OP_FIND,
					8'($urandom), 1'($urandom), 7'($urandom));
				default: add_cmd(3'($urandom_range(6, 7)), 8'($urandom), 1'($urandom),
					7'($urandom));
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_WRITE;
		char_in = 0;
		quote_in = 0;
		count_in = 0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_DELIM_A;
		cfg_data = 0;
		error_count = 0;
		idle_cycles = 0;
		stimulus_done = 0;
		head_ptr = 0;
		tail_ptr = 0;
		delims[0] = 8'd10;
		delims[1] = 0;
		delims[2] = 0;
		delims[3] = 0;
		delim_en = 4'd1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty cases, escapes, find, full counts, unused codes.
		add_cmd(OP_READ, 0, 0, 7'd5);
		add_cmd(OP_DROP, 0, 0, 7'd5);
		add_cmd(OP_ERASE, 0, 0, 0);
		add_cmd(OP_FIND, 0, 0, 0);
		add_write(BYTE_FF, 1'b1);
		add_cmd(OP_ERASE, 0, 0, 0);
		add_write(BYTE_FF, 1'b0);
		add_write(BYTE_FF, 1'b1);
		add_cmd(OP_ERASE, 0, 0, 0);
		add_write(BYTE_FF, 1'b0);
		add_write(BYTE_00, 1'b0);
		add_write(8'h41, 1'b1);
		add_cmd(OP_ERASE, 0, 0, 0);
		add_write(8'h55, 1'b0);
		add_write(8'hAA, 1'b1);
		add_write(8'd10, 1'b0);
		add_cmd(OP_FIND, 0, 0, 0);
		add_cmd(OP_READ, 0, 0, 7'd0);
		add_cmd(OP_READ, 0, 0, 7'd127);
		add_write(8'h7f, 1'b0);
		add_cmd(OP_FIND, 0, 0, 0);
		add_cmd(OP_DROP, 0, 0, 7'd64);
		add_cmd(3'd6, 0, 0, 0);
		add_cmd(3'd7, 0, 0, 0);
		add_cmd(OP_FLUSH, 0, 0, 0);
		wait_drained();

		// Several delimiter settings, extremes included.
		write_reg(CFG_DELIM_A, 8'hff);
		write_reg(CFG_DELIM_B, 8'h00);
		write_reg(CFG_DELIM_C, 8'h0d);
		write_reg(CFG_DELIM_D, 8'h20);
		write_reg(CFG_ENABLE, 4'hf);
		random_phase(110);
		wait_drained();
		write_reg(CFG_ENABLE, 4'h0);
		random_phase(60);
		wait_drained();
		write_reg(CFG_DELIM_A, 8'($urandom));
		write_reg(CFG_DELIM_C, 8'($urandom));
		write_reg(CFG_ENABLE, 4'($urandom_range(1, 14)));
		random_phase(110);
		wait_drained();
		write_reg(CFG_DELIM_B, 8'h0a);
		write_reg(CFG_ENABLE, 4'b0110);
		random_phase(70);
		wait_drained();
		stimulus_done = 1;
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule
